[design/dstg_pkg.sv]
`timescale 1ns / 1ps

package dstg_pkg;

  // Payload widths
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned ENV_W     = 32;
  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // Sine table entries are Q1.30, at most 1.0
  localparam int unsigned SINE_W = 31;

  // pi/2 in Q30
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Register defaults
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd97391549;
  localparam logic [ENV_W-1:0]   DECAY_FACTOR_RST = 32'd4294788035;
  localparam logic [ENV_W-1:0]   START_LEVEL_RST  = 32'd2147483648;
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 24'd220500;

  // Full-scale sample magnitude
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'd32767;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_DECAY_FACTOR = 2'd1,
    REG_START_LEVEL  = 2'd2,
    REG_SAMPLE_COUNT = 2'd3
  } dstg_reg_t;

endpackage

[design/dstg_in_if.sv]
`timescale 1ns / 1ps

interface dstg_in_if;
  import dstg_pkg::*;

  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

[design/dstg_out_if.sv]
`timescale 1ns / 1ps

interface dstg_out_if;
  import dstg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

[design/dstg_cfg_if.sv]
`timescale 1ns / 1ps

interface dstg_cfg_if;
  import dstg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/dstg_sine_rom.sv]
`timescale 1ns / 1ps

// Quarter-wave sine ROM, 2^TABLE_BITS + 1 entries in Q1.30, registered read.
// Contents are worked out at elaboration by an integer Taylor series.
module dstg_sine_rom #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [TABLE_BITS:0]          addr,
  output logic [dstg_pkg::SINE_W-1:0]  data_r
);
  import dstg_pkg::*;

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  // sin(x) for x = i * (pi/2) / 2^TABLE_BITS, Taylor series up to x^15.
  // Each term is the previous one times x^2 over (2k)(2k+1), signs alternate.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x   = (longint'(i) * longint'(HALF_PI_Q30)) >> TABLE_BITS;
    x2  = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(1 << 30)) begin
      acc = longint'(1 << 30);
    end
    return SINE_W'(acc);
  endfunction

  logic [SINE_W-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [SINE_W-1:0] ENTRY = sine_entry(g);
    assign rom[g] = ENTRY;
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rom[addr];
    end
  end

endmodule

[design/decaying_sine_tone_generator.sv]
`timescale 1ns / 1ps

// Each sample passes stage 1, stage 2 and the output register.
// Throughput: one tick per cycle while out_if is ready; the envelope multiply
// and phase add are combinational, sample scaling spans three pipeline stages.
// Reset (rst_n low, synchronous): registers take their defaults, phase and
// sample index clear, envelope loads 2^31, the pipeline empties.
module decaying_sine_tone_generator #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input logic       clk,
  input logic       rst_n,
  dstg_in_if.sink   in_if,
  dstg_out_if.source out_if,
  dstg_cfg_if.sink  cfg_if
);
  import dstg_pkg::*;

  localparam int unsigned PROD_W = ENV_W + SINE_W - 16;   // (env * s) >> 16
  localparam int unsigned SCALE_W = PROD_W + 15;          // * 32767

  // Configuration registers
  logic [PHASE_W-1:0] phase_step_r;
  logic [ENV_W-1:0]   decay_factor_r;
  logic [ENV_W-1:0]   start_level_r;
  logic [COUNT_W-1:0] sample_count_r;

  // Tone state
  logic [PHASE_W-1:0] phase_acc_r, phase_acc_nxt;
  logic [ENV_W-1:0]   envelope_r, envelope_nxt;
  logic [COUNT_W-1:0] sample_index_r, sample_index_nxt;

  // Pipeline control
  logic out_valid_r, s1_valid_r, s2_valid_r;
  logic out_load, s2_load, s1_load, in_xfer;

  // Stage 1: envelope and flags, sine from the ROM
  logic              s1_act_r, s1_neg_r, s1_last_r;
  logic [ENV_W-1:0]  s1_env_r;
  logic [SINE_W-1:0] s1_sine;

  // Stage 2: partial product
  logic              s2_act_r, s2_neg_r, s2_last_r;
  logic [PROD_W-1:0] s2_prod_r;

  // Output register
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  // Tick decode
  logic [PHASE_W-1:0]         base_phase;
  logic [ENV_W-1:0]           base_env;
  logic [COUNT_W-1:0]         base_index;
  logic [COUNT_W-1:0]         index_inc;
  logic                       active;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [SINE_TABLE_BITS:0]   rom_addr;
  logic [2*ENV_W-1:0]         decay_prod;

  // Scaling
  logic [ENV_W+SINE_W-1:0]    env_sine;
  logic [SCALE_W-1:0]         scaled;
  logic [SCALE_W-46:0]        mag_wide;
  logic [SAMPLE_W-1:0]        mag;

  // Elastic pipeline: each stage loads when empty or when it drains
  assign out_load = !out_valid_r || out_if.ready;
  assign s2_load  = !s2_valid_r || out_load;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_if.ready = s1_load;
  assign in_xfer  = in_if.valid && s1_load;

  assign cfg_if.ready = 1'b1;

  // Restart takes effect before this sample is made
  always_comb begin
    base_phase = in_if.restart ? '0 : phase_acc_r;
    base_env   = in_if.restart ? start_level_r : envelope_r;
    base_index = in_if.restart ? '0 : sample_index_r;
  end

  assign active    = base_index < sample_count_r;
  assign index_inc = base_index + COUNT_W'(1);

  // Quarter-wave fold of the phase
  assign tab_idx  = base_phase[PHASE_W-3 -: SINE_TABLE_BITS];
  assign rom_addr = base_phase[PHASE_W-2]
                  ? ({1'b1, {SINE_TABLE_BITS{1'b0}}} - {1'b0, tab_idx})
                  : {1'b0, tab_idx};

  // Next tone state
  assign decay_prod = base_env * decay_factor_r;

  always_comb begin
    phase_acc_nxt    = base_phase;
    envelope_nxt     = base_env;
    sample_index_nxt = base_index;
    if (active) begin
      phase_acc_nxt    = base_phase + phase_step_r;
      envelope_nxt     = decay_prod[2*ENV_W-1 -: ENV_W];
      sample_index_nxt = index_inc;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= PHASE_STEP_RST;
      decay_factor_r <= DECAY_FACTOR_RST;
      start_level_r  <= START_LEVEL_RST;
      sample_count_r <= SAMPLE_COUNT_RST;
    end else if (cfg_if.valid) begin
      case (dstg_reg_t'(cfg_if.index))
        REG_PHASE_STEP:   phase_step_r   <= cfg_if.data;
        REG_DECAY_FACTOR: decay_factor_r <= cfg_if.data;
        REG_START_LEVEL:  start_level_r  <= cfg_if.data;
        REG_SAMPLE_COUNT: sample_count_r <= cfg_if.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Tone state advances on each tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r    <= '0;
      envelope_r     <= START_LEVEL_RST;
      sample_index_r <= '0;
    end else if (in_xfer) begin
      phase_acc_r    <= phase_acc_nxt;
      envelope_r     <= envelope_nxt;
      sample_index_r <= sample_index_nxt;
    end
  end

  // Sine lookup, read registered into stage 1
  dstg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk    (clk),
    .en     (s1_load),
    .addr   (rom_addr),
    .data_r (s1_sine)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_if.valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_load) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_act_r  <= active;
      s1_neg_r  <= base_phase[PHASE_W-1];
      s1_last_r <= active && (index_inc == sample_count_r);
      s1_env_r  <= base_env;
    end
  end

  // Stage 2: envelope times sine, low 16 bits dropped
  assign env_sine = s1_env_r * s1_sine;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_act_r  <= s1_act_r;
      s2_neg_r  <= s1_neg_r;
      s2_last_r <= s1_last_r;
      s2_prod_r <= env_sine[ENV_W+SINE_W-1:16];
    end
  end

  // Output stage: times 32767 as shift and subtract, then >> 45 and saturate
  assign scaled   = {s2_prod_r, 15'd0} - SCALE_W'(s2_prod_r);
  assign mag_wide = scaled[SCALE_W-1:45];
  assign mag      = (mag_wide > (SCALE_W-45)'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                           : mag_wide[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (!s2_act_r) begin
        out_sample_r <= '0;
      end else if (s2_neg_r) begin
        out_sample_r <= -$signed(mag);
      end else begin
        out_sample_r <= $signed(mag);
      end
      out_last_r <= s2_last_r;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.sample = out_sample_r;
  assign out_if.last   = out_last_r;

endmodule
